/* rtl/nnts_pkg.sv */
// Shared types, register indexes and pixel conversion for the thumbnail scaler.
package nnts_pkg;

    localparam int PIXEL_W     = 32;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [15:0]        RGB565_RED   = 16'hF800;
    localparam logic [15:0]        RGB565_GREEN = 16'h07E0;
    localparam logic [15:0]        RGB565_BLUE  = 16'h001F;

    localparam int RESET_SOURCE_WIDTH  = 640;
    localparam int RESET_SOURCE_HEIGHT = 480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_PIXEL_FORMAT  = 2'd2
    } reg_index_t;

    typedef enum logic {
        FMT_RGB565   = 1'b0,
        FMT_XRGB8888 = 1'b1
    } pixel_format_t;

    // Widen RGB565 by shifting only; pass 32-bit pixels through. Force alpha.
    function automatic logic [PIXEL_W-1:0] widen_pixel(input logic [PIXEL_W-1:0] pix,
                                                       input pixel_format_t fmt);
        logic [PIXEL_W-1:0] rgb;
        if (fmt == FMT_XRGB8888) begin
            rgb = pix;
        end else begin
            rgb = ({16'b0, pix[15:0] & RGB565_RED}   << 8)
                | ({16'b0, pix[15:0] & RGB565_GREEN} << 5)
                | ({16'b0, pix[15:0] & RGB565_BLUE}  << 3);
        end
        return ALPHA_OPAQUE | rgb;
    endfunction

endpackage

/* rtl/nearest_neighbor_thumbnail_scaler.sv */
// Nearest-neighbor thumbnail scaler: raster source pixels in, ARGB8888 thumbnail out.
// A selected pixel appears on m_valid in the cycle after its input transaction.
// Throughput: one source pixel per cycle; the single output register is the only stage,
// and s_ready stays high whenever that register is empty or is being drained.
// Reset (aresetn, synchronous, active low) restores 640x480 RGB565, clears all position
// counters and accumulators, and empties the output register.
module nearest_neighbor_thumbnail_scaler #(
    parameter int THUMB_WIDTH    = 128,
    parameter int THUMB_HEIGHT   = 128,
    parameter int MAX_SOURCE_DIM = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [nnts_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [nnts_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    // Source pixel stream
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [nnts_pkg::PIXEL_W-1:0]       s_source_pixel,

    // Thumbnail pixel stream
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [nnts_pkg::PIXEL_W-1:0]       m_argb_pixel,
    output logic [$clog2(THUMB_WIDTH)-1:0]     m_thumb_x,
    output logic [$clog2(THUMB_HEIGHT)-1:0]    m_thumb_y,
    output logic                               m_frame_last
);
    import nnts_pkg::*;

    localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int POS_W  = $clog2(MAX_SOURCE_DIM);
    localparam int X_W    = $clog2(THUMB_WIDTH);
    localparam int Y_W    = $clog2(THUMB_HEIGHT);
    localparam int NTC_W  = $clog2(THUMB_WIDTH + 1);
    localparam int NTR_W  = $clog2(THUMB_HEIGHT + 1);
    localparam int CACC_W = $clog2(THUMB_WIDTH * MAX_SOURCE_DIM + 1);
    localparam int RACC_W = $clog2(THUMB_HEIGHT * MAX_SOURCE_DIM + 1);

    // Reset sizes, capped at MAX_SOURCE_DIM so they never exceed the maximum.
    localparam int RST_W = (RESET_SOURCE_WIDTH > MAX_SOURCE_DIM) ?
                           MAX_SOURCE_DIM : RESET_SOURCE_WIDTH;
    localparam int RST_H = (RESET_SOURCE_HEIGHT > MAX_SOURCE_DIM) ?
                           MAX_SOURCE_DIM : RESET_SOURCE_HEIGHT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg,  width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    pixel_format_t    format_reg, format_next;

    // Saturate a size write into [lo, MAX_SOURCE_DIM].
    function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                    input int lo);
        logic [DIM_W-1:0] s;
        if (32'(v) < lo) begin
            s = DIM_W'(lo);
        end else if (32'(v) > MAX_SOURCE_DIM) begin
            s = DIM_W'(MAX_SOURCE_DIM);
        end else begin
            s = DIM_W'(v);
        end
        return s;
    endfunction

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        format_next = format_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SOURCE_WIDTH:  width_next  = clamp_size(cfg_wr_data, THUMB_WIDTH);
                REG_SOURCE_HEIGHT: height_next = clamp_size(cfg_wr_data, THUMB_HEIGHT);
                REG_PIXEL_FORMAT:  format_next = pixel_format_t'(cfg_wr_data[0]);
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position state
    //   src_col/src_row   : position of the next source pixel
    //   col_pos/row_pos   : the same position scaled by the thumbnail size
    //   ntc/ntr           : next thumbnail column/row to emit
    //   col_acc/row_acc   : ntc * W and ntr * H (sums of the sizes in force)
    // Source column c matches thumbnail column n when
    //   c*THUMB_WIDTH <= n*W < (c+1)*THUMB_WIDTH, i.e. c == floor(n*W/THUMB_WIDTH),
    // which avoids any divider. Rows work the same way.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  src_col_reg, src_col_next;
    logic [POS_W-1:0]  src_row_reg, src_row_next;
    logic [CACC_W-1:0] col_pos_reg, col_pos_next;
    logic [RACC_W-1:0] row_pos_reg, row_pos_next;
    logic [NTC_W-1:0]  ntc_reg,     ntc_next;
    logic [NTR_W-1:0]  ntr_reg,     ntr_next;
    logic [CACC_W-1:0] col_acc_reg, col_acc_next;
    logic [RACC_W-1:0] row_acc_reg, row_acc_next;

    // Output register
    logic                 m_valid_reg,      m_valid_next;
    logic [PIXEL_W-1:0]   m_argb_pixel_reg, m_argb_pixel_next;
    logic [X_W-1:0]       m_thumb_x_reg,    m_thumb_x_next;
    logic [Y_W-1:0]       m_thumb_y_reg,    m_thumb_y_next;
    logic                 m_frame_last_reg, m_frame_last_next;

    logic s_accept;
    logic row_hit;
    logic col_hit;
    logic pix_hit;
    logic row_end;
    logic frame_end;

    // Accept a new pixel whenever the output register is empty or drains this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign row_hit = (ntr_reg < NTR_W'(THUMB_HEIGHT))
                  && (row_acc_reg >= row_pos_reg)
                  && (row_acc_reg <  row_pos_reg + RACC_W'(THUMB_HEIGHT));
    assign col_hit = (ntc_reg < NTC_W'(THUMB_WIDTH))
                  && (col_acc_reg >= col_pos_reg)
                  && (col_acc_reg <  col_pos_reg + CACC_W'(THUMB_WIDTH));
    assign pix_hit = row_hit && col_hit;

    // ">=" so a mid-frame size shrink still closes the row or frame.
    assign row_end   = (DIM_W'(src_col_reg) + DIM_W'(1)) >= width_reg;
    assign frame_end = (DIM_W'(src_row_reg) + DIM_W'(1)) >= height_reg;

    always_comb begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        ntc_next     = ntc_reg;
        ntr_next     = ntr_reg;
        col_acc_next = col_acc_reg;
        row_acc_next = row_acc_reg;

        // Hold the output until taken; load it when a selected pixel arrives.
        m_valid_next      = m_valid_reg && !m_ready;
        m_argb_pixel_next = m_argb_pixel_reg;
        m_thumb_x_next    = m_thumb_x_reg;
        m_thumb_y_next    = m_thumb_y_reg;
        m_frame_last_next = m_frame_last_reg;

        if (s_accept) begin
            m_valid_next = pix_hit;
            if (pix_hit) begin
                m_argb_pixel_next = widen_pixel(s_source_pixel, format_reg);
                m_thumb_x_next    = X_W'(ntc_reg);
                m_thumb_y_next    = Y_W'(ntr_reg);
                m_frame_last_next = (ntc_reg == NTC_W'(THUMB_WIDTH - 1))
                                 && (ntr_reg == NTR_W'(THUMB_HEIGHT - 1));
                ntc_next     = ntc_reg + NTC_W'(1);
                col_acc_next = col_acc_reg + CACC_W'(width_reg);
            end

            if (row_end) begin
                if (frame_end) begin
                    // Wrap the frame: realign everything.
                    src_col_next = '0;
                    src_row_next = '0;
                    col_pos_next = '0;
                    row_pos_next = '0;
                    ntc_next     = '0;
                    ntr_next     = '0;
                    col_acc_next = '0;
                    row_acc_next = '0;
                end else begin
                    src_col_next = '0;
                    col_pos_next = '0;
                    src_row_next = src_row_reg + POS_W'(1);
                    row_pos_next = row_pos_reg + RACC_W'(THUMB_HEIGHT);
                    ntc_next     = '0;
                    col_acc_next = '0;
                    if (row_hit) begin
                        ntr_next     = ntr_reg + NTR_W'(1);
                        row_acc_next = row_acc_reg + RACC_W'(height_reg);
                    end
                end
            end else begin
                src_col_next = src_col_reg + POS_W'(1);
                col_pos_next = col_pos_reg + CACC_W'(THUMB_WIDTH);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(RST_W);
            height_reg  <= DIM_W'(RST_H);
            format_reg  <= FMT_RGB565;
            src_col_reg <= '0;
            src_row_reg <= '0;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            ntc_reg     <= '0;
            ntr_reg     <= '0;
            col_acc_reg <= '0;
            row_acc_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            format_reg  <= format_next;
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            ntc_reg     <= ntc_next;
            ntr_reg     <= ntr_next;
            col_acc_reg <= col_acc_next;
            row_acc_reg <= row_acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        m_argb_pixel_reg <= m_argb_pixel_next;
        m_thumb_x_reg    <= m_thumb_x_next;
        m_thumb_y_reg    <= m_thumb_y_next;
        m_frame_last_reg <= m_frame_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_argb_pixel = m_argb_pixel_reg;
    assign m_thumb_x    = m_thumb_x_reg;
    assign m_thumb_y    = m_thumb_y_reg;
    assign m_frame_last = m_frame_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The thumbnail counters never run past the thumbnail size.
    a_thumb_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ntc_reg <= NTC_W'(THUMB_WIDTH)) && (ntr_reg <= NTR_W'(THUMB_HEIGHT)))
        else $error("thumbnail counter out of range");

    // The last source pixel of a frame realigns all position state.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && row_end && frame_end) |=>
        (src_col_reg == '0) && (src_row_reg == '0) && (ntr_reg == '0)
        && (row_acc_reg == '0) && (col_acc_reg == '0))
        else $error("frame wrap did not clear position state");

    // An emitted pixel inside a row advances the thumbnail column by one.
    a_col_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && pix_hit && !row_end) |=>
        (ntc_reg == $past(ntc_reg) + NTC_W'(1)) && m_valid)
        else $error("column did not advance on emitted pixel");

endmodule

/* tb/nearest_neighbor_thumbnail_scaler_test.sv */
// Self-checking testbench for the nearest-neighbor thumbnail scaler.
module nearest_neighbor_thumbnail_scaler_test;
    import nnts_pkg::*;

    localparam int THUMB_W       = 128;
    localparam int THUMB_H       = 128;
    localparam int MAX_DIM       = 4096;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    // One output register: a result shows in the cycle after its source transaction.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_CYCLES = 1000000;
    // Pixels per stretch on the fixed 128x129 geometry.
    localparam int GEOMETRY_RUN  = 250;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] argb;
        logic [6:0]         col;
        logic [6:0]         row;
        logic               last;
    } thumb_pixel_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_source_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic [PIXEL_W-1:0]     m_argb_pixel;
    logic [6:0]             m_thumb_x;
    logic [6:0]             m_thumb_y;
    logic                   m_frame_last;

    nearest_neighbor_thumbnail_scaler #(
        .THUMB_WIDTH   (THUMB_W),
        .THUMB_HEIGHT  (THUMB_H),
        .MAX_SOURCE_DIM(MAX_DIM)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_pixel(s_source_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_argb_pixel  (m_argb_pixel),
        .m_thumb_x     (m_thumb_x),
        .m_thumb_y     (m_thumb_y),
        .m_frame_last  (m_frame_last)
    );

    // Source pixels waiting for the driver, and thumbnail pixels still owed by the block.
    logic [PIXEL_W-1:0] pending_pixels[$];
    thumb_pixel_t       expected_thumb[$];

    // Scaler state as the block should hold it.
    logic [12:0]   cur_width;
    logic [12:0]   cur_height;
    pixel_format_t cur_format;
    logic [11:0]   src_col;
    logic [11:0]   src_row;
    logic [7:0]    thumb_col;
    logic [7:0]    thumb_row;
    logic [19:0]   col_acc;
    logic [19:0]   row_acc;

    // Traffic shaping.
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests;
    logic receiver_held;
    logic pixel_taken;

    // Run statistics.
    int mismatch_count;
    int pixels_accepted;
    int thumbs_checked;
    int thumbs_completed;
    int register_writes;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic void restart_position();
        src_col   = '0;
        src_row   = '0;
        thumb_col = '0;
        thumb_row = '0;
        col_acc   = '0;
        row_acc   = '0;
    endfunction

    // Raise sizes below the thumbnail to the thumbnail, cap sizes above the maximum.
    function automatic logic [12:0] clamp_dimension(input logic [12:0] raw, input int floor_dim);
        if (32'(raw) < floor_dim) return 13'(floor_dim);
        if (32'(raw) > MAX_DIM) return 13'(MAX_DIM);
        return raw;
    endfunction

    // Advance the scaler by one source pixel; return 1 when it selects a thumbnail pixel.
    function automatic bit scale_source_pixel(input logic [PIXEL_W-1:0] pix,
                                              output thumb_pixel_t thumb);
        bit row_hit;
        bit col_hit;
        row_hit = (thumb_row < 8'(THUMB_H)) && (20'(src_row) == row_acc / 20'(THUMB_H));
        col_hit = row_hit && (thumb_col < 8'(THUMB_W))
               && (20'(src_col) == col_acc / 20'(THUMB_W));
        thumb = '0;
        if (col_hit) begin
            // RGB565 widens by shifting alone; upper 16 bits are dropped.
            if (cur_format == FMT_XRGB8888)
                thumb.argb = ALPHA_OPAQUE | pix;
            else
                thumb.argb = ALPHA_OPAQUE | {8'h00, pix[15:11], 3'b000, pix[10:5], 2'b00,
                                             pix[4:0], 3'b000};
            thumb.col  = thumb_col[6:0];
            thumb.row  = thumb_row[6:0];
            thumb.last = (thumb_col == 8'(THUMB_W - 1)) && (thumb_row == 8'(THUMB_H - 1));
            thumb_col  = thumb_col + 8'd1;
            col_acc    = col_acc + 20'(cur_width);
        end
        // Compare with ">=" so a width or height shrunk mid-frame still ends the row.
        if ((13'(src_col) + 13'd1) >= cur_width) begin
            if ((13'(src_row) + 13'd1) >= cur_height) begin
                restart_position();
            end else begin
                src_col   = '0;
                src_row   = src_row + 12'd1;
                thumb_col = '0;
                col_acc   = '0;
                if (row_hit) begin
                    thumb_row = thumb_row + 8'd1;
                    row_acc   = row_acc + 20'(cur_height);
                end
            end
        end else begin
            src_col = src_col + 12'd1;
        end
        return col_hit;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Driver: present the next pending pixel once the previous transaction is done,
    // idling at random. Hold valid and payload steady until the block takes them.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pixel_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_valid        <= 1'b1;
                s_source_pixel <= pending_pixels.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, and drop ready for the whole of a requested hold-off.
    always @(negedge aclk) begin
        if (!aresetn || receiver_held)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Long receiver hold-off, timed here so the stimulus keeps feeding the block.
    always @(hold_requests) begin
        receiver_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        receiver_held <= 1'b0;
    end

    // Monitor: check each thumbnail transaction against the oldest prediction,
    // then predict from any source transaction taken at this edge.
    always @(posedge aclk) begin : monitor
        thumb_pixel_t observed;
        thumb_pixel_t wanted;
        thumb_pixel_t predicted;
        pixel_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            observed = {m_argb_pixel, m_thumb_x, m_thumb_y, m_frame_last};
            if (expected_thumb.size() == 0) begin
                note_mismatch($sformatf({"[%0t] unexpected thumbnail pixel argb=%08h ",
                                         "x=%0d y=%0d last=%0b"},
                                        $time, observed.argb, observed.col, observed.row,
                                        observed.last));
            end else begin
                wanted = expected_thumb.pop_front();
                if (observed.argb !== wanted.argb || observed.col !== wanted.col ||
                    observed.row !== wanted.row || observed.last !== wanted.last) begin
                    note_mismatch($sformatf({"[%0t] thumbnail mismatch: expected argb=%08h ",
                                             "x=%0d y=%0d last=%0b, got argb=%08h x=%0d ",
                                             "y=%0d last=%0b"},
                                            $time, wanted.argb, wanted.col, wanted.row,
                                            wanted.last, observed.argb, observed.col,
                                            observed.row, observed.last));
                end
            end
            thumbs_checked++;
            if (observed.last === 1'b1) thumbs_completed++;
        end
        if (aresetn && s_valid && s_ready) begin
            if (scale_source_pixel(s_source_pixel, predicted)) expected_thumb.push_back(predicted);
            pixels_accepted++;
        end
    end

    // Write one register while the block is idle and mirror it in the prediction.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            REG_SOURCE_WIDTH:  cur_width  = clamp_dimension(data, THUMB_W);
            REG_SOURCE_HEIGHT: cur_height = clamp_dimension(data, THUMB_H);
            REG_PIXEL_FORMAT:  cur_format = pixel_format_t'(data[0]);
            default: ;
        endcase
        register_writes++;
    endtask

    // Hold off until the driver has nothing left and every owed result has arrived.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        // Sample the driver side at the rising edge, where its outputs are stable.
        do @(posedge aclk); while (pending_pixels.size() != 0 || s_valid);
        while (expected_thumb.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        // A last pixel that selects nothing may still be in flight.
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dimension_code();
        int roll;
        logic [CFG_DATA_W-1:0] code;
        roll = $urandom_range(99);
        if (roll < 70)      code = CFG_DATA_W'($urandom_range(THUMB_W, 320));
        else if (roll < 80) code = CFG_DATA_W'($urandom_range(0, THUMB_W - 1));
        else if (roll < 90) code = CFG_DATA_W'($urandom_range(MAX_DIM + 1, 8191));
        else                code = CFG_DATA_W'(MAX_DIM);
        return code;
    endfunction

    // Mostly full-range pixels, with all-zero, all-one and low-half-only ones mixed in.
    task automatic queue_random_pixels(input int count);
        logic [PIXEL_W-1:0] pix;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       pix = '0;
                1:       pix = '1;
                2:       pix = $urandom & 32'h0000_FFFF;
                default: pix = $urandom;
            endcase
            pending_pixels.push_back(pix);
        end
    endtask

    initial begin : stimulus
        logic [PIXEL_W-1:0] reset_format_pixels[12];
        logic [PIXEL_W-1:0] wide_format_pixels[12];
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_index    = '0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_source_pixel  = '0;
        m_ready         = 1'b0;
        receiver_held   = 1'b0;
        pixel_taken     = 1'b0;
        hold_requests   = 0;
        mismatch_count  = 0;
        pixels_accepted = 0;
        thumbs_checked  = 0;
        thumbs_completed = 0;
        register_writes = 0;
        cur_width       = 13'(RESET_SOURCE_WIDTH);
        cur_height      = 13'(RESET_SOURCE_HEIGHT);
        cur_format      = FMT_RGB565;
        restart_position();

        // Sender light, receiver stalling heavily.
        sender_idle_pct   = 15;
        receiver_idle_pct = 68;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry 640x480 RGB565: columns 0, 5 and 10 are selected. Put the
        // color extremes there, with junk in the upper half that must be dropped.
        reset_format_pixels = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_F800,
                                32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_07E0, 32'h0000_001F};
        foreach (reset_format_pixels[i]) pending_pixels.push_back(reset_format_pixels[i]);
        wait_until_drained();

        // Shrink width and height below the thumbnail mid-frame (both clamp to 128),
        // switch to 32-bit pixels, and poke the unmapped index. The column
        // accumulator still points past the current column, so the first few skip.
        write_register(REG_SOURCE_WIDTH, 13'd0);
        write_register(REG_SOURCE_HEIGHT, 13'd100);
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_XRGB8888));
        write_register(REG_UNMAPPED, 13'h1FFF);
        wide_format_pixels = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h00FF_FFFF,
                               32'h8000_0001, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0012_3456,
                               32'hFF00_0000, 32'h7FFF_FFFE};
        foreach (wide_format_pixels[i]) pending_pixels.push_back(wide_format_pixels[i]);
        wait_until_drained();

        // 128x129 geometry, first stretch in RGB565. Hold the receiver off for a long
        // stretch while the driver keeps offering, so the block backs up its input.
        write_register(REG_SOURCE_WIDTH, 13'd128);
        write_register(REG_SOURCE_HEIGHT, 13'd129);
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB565));
        queue_random_pixels(GEOMETRY_RUN);
        hold_requests++;
        wait_until_drained();

        // Swap the stall pattern: sender idles heavily, receiver lightly.
        sender_idle_pct   = 68;
        receiver_idle_pct = 15;

        // Second stretch in 32-bit pixels on the same geometry, across several rows.
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_XRGB8888));
        queue_random_pixels(GEOMETRY_RUN + 200);
        wait_until_drained();

        // Oversize writes cap at the maximum; then the maximum width on the
        // smallest height.
        write_register(REG_SOURCE_WIDTH, 13'h1FFF);
        write_register(REG_SOURCE_HEIGHT, 13'h1FFF);
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB565));
        queue_random_pixels(150);
        wait_until_drained();
        write_register(REG_SOURCE_WIDTH, 13'(MAX_DIM));
        write_register(REG_SOURCE_HEIGHT, 13'(THUMB_H));
        queue_random_pixels(150);
        wait_until_drained();

        // Random geometry and format per burst; the last bursts run with no idling.
        for (int burst = 0; burst < 6; burst++) begin
            if (burst == 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_register(REG_SOURCE_WIDTH, pick_dimension_code());
            write_register(REG_SOURCE_HEIGHT, pick_dimension_code());
            write_register(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(1)));
            queue_random_pixels($urandom_range(100, 180));
            wait_until_drained();
        end

        if (expected_thumb.size() != 0)
            $display("%0d predicted thumbnail pixels never arrived", expected_thumb.size());
        $display("Covered %0d source pixels, %0d thumbnail pixels, %0d complete thumbnails,",
                 pixels_accepted, thumbs_checked, thumbs_completed);
        $display("%0d register writes incl. clamped, capped and mid-frame size changes",
                 register_writes);
        if (mismatch_count == 0 && expected_thumb.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
